FILE: rtl/clwu_pkg.sv
// clwu_pkg: shared types and constants for the competitive-learning winner block.
// No dependencies.
`default_nettype none
package clwu_pkg;

   localparam int MAX_INPUTS       = 64;
   localparam int MAX_OUTPUTS      = 16;
   localparam int LINE_W           = 6;
   localparam int UNIT_W           = 4;
   localparam int WEIGHT_W         = 17;
   localparam int SUM_W            = 23;
   localparam int COUNT_W          = 7;
   localparam int DIV_STEPS        = 17;

   localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'h10000;

   localparam logic [1:0] KIND_WRITE   = 2'd0;
   localparam logic [1:0] KIND_READ    = 2'd1;
   localparam logic [1:0] KIND_PATTERN = 2'd2;

   localparam logic [1:0] CSR_NUM_INPUTS   = 2'd0;
   localparam logic [1:0] CSR_NUM_OUTPUTS  = 2'd1;
   localparam logic [1:0] CSR_LEARN_RATE   = 2'd2;
   localparam logic [1:0] CSR_LEARN_ENABLE = 2'd3;

   typedef struct packed {
      logic [1:0]          kind;
      logic [UNIT_W-1:0]   unit_index;
      logic [LINE_W-1:0]   input_index;
      logic [WEIGHT_W-1:0] weight_value;
      logic [63:0]         pattern_bits;
   } req_type;

   typedef struct packed {
      logic [UNIT_W-1:0]   winner;
      logic [WEIGHT_W-1:0] read_value;
      logic [COUNT_W-1:0]  active_count;
      logic                error;
   } rsp_type;

   typedef enum logic [1:0] {
      ADDR_ITEM,
      ADDR_SWEEP,
      ADDR_WINNER
   } addr_sel_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SUM,
      ST_SUM_DRAIN,
      ST_CHECK,
      ST_RECIP,
      ST_UPD_RD,
      ST_UPD_MUL,
      ST_UPD_WR,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic              load_item;
      addr_sel_type      addr_sel;
      logic [UNIT_W-1:0] unit;
      logic [LINE_W-1:0] line;
      logic              mem_rd;
      logic              mem_wr_item;
      logic              mem_wr_upd;
      logic              sum_valid;
      logic              sum_first;
      logic              sum_last;
      logic              div_step;
      logic              div_first;
      logic              mul_en;
      logic              load_rsp;
   } cmd_type;

   typedef struct packed {
      logic [1:0] kind;
      logic       item_err;
      logic       learn_go;
      logic       rsp_free;
   } status_type;

endpackage
`default_nettype wire

FILE: rtl/clwu_ctrl.sv
// clwu_ctrl: sequencer for item decode, sum sweep, reciprocal and winner update.
// Depends on clwu_pkg.
`default_nettype none
module clwu_ctrl
   import clwu_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [COUNT_W-1:0] n_in,
   input  wire logic [4:0]         n_out,
   input  wire status_type         status,
   output cmd_type                 cmd
);

   state_type         state_ff, state_in;
   logic [UNIT_W-1:0] u_ff, u_in;
   logic [LINE_W-1:0] i_ff, i_in;
   logic              line_last;
   logic              unit_last;

   assign line_last = ({1'b0, i_ff} == (n_in - 7'd1));
   assign unit_last = ({1'b0, u_ff} == (n_out - 5'd1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         u_ff     <= '0;
         i_ff     <= '0;
      end else begin
         state_ff <= state_in;
         u_ff     <= u_in;
         i_ff     <= i_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      u_in      = u_ff;
      i_in      = i_ff;
      cmd       = '0;
      cmd.addr_sel = ADDR_ITEM;
      cmd.unit  = u_ff;
      cmd.line  = i_ff;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = ST_DECODE;
            end
         end
         ST_DECODE: begin
            u_in     = '0;
            i_in     = '0;
            state_in = ST_DONE;
            if (status.kind == KIND_WRITE && !status.item_err) begin
               cmd.mem_wr_item = 1'b1;
            end else if (status.kind == KIND_READ && !status.item_err) begin
               cmd.mem_rd = 1'b1;
            end else if (status.kind == KIND_PATTERN) begin
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            cmd.addr_sel  = ADDR_SWEEP;
            cmd.mem_rd    = 1'b1;
            cmd.sum_valid = 1'b1;
            cmd.sum_first = (i_ff == '0);
            cmd.sum_last  = line_last;
            if (line_last) begin
               i_in = '0;
               if (unit_last) begin
                  state_in = ST_SUM_DRAIN;
               end else begin
                  u_in = u_ff + 4'd1;
               end
            end else begin
               i_in = i_ff + 6'd1;
            end
         end
         ST_SUM_DRAIN: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            i_in     = '0;
            state_in = status.learn_go ? ST_RECIP : ST_DONE;
         end
         ST_RECIP: begin
            cmd.div_step  = 1'b1;
            cmd.div_first = (i_ff == '0);
            if (i_ff == LINE_W'(DIV_STEPS - 1)) begin
               i_in     = '0;
               state_in = ST_UPD_RD;
            end else begin
               i_in = i_ff + 6'd1;
            end
         end
         ST_UPD_RD: begin
            cmd.addr_sel = ADDR_WINNER;
            cmd.mem_rd   = 1'b1;
            state_in     = ST_UPD_MUL;
         end
         ST_UPD_MUL: begin
            cmd.mul_en = 1'b1;
            state_in   = ST_UPD_WR;
         end
         ST_UPD_WR: begin
            cmd.addr_sel   = ADDR_WINNER;
            cmd.mem_wr_upd = 1'b1;
            if (line_last) begin
               state_in = ST_DONE;
            end else begin
               i_in     = i_ff + 6'd1;
               state_in = ST_UPD_RD;
            end
         end
         ST_DONE: begin
            if (status.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

`ifndef SYNTHESIS
   a_recip_to_update: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RECIP && i_ff == LINE_W'(DIV_STEPS - 1)) |=> state_ff == ST_UPD_RD)
      else $error("reciprocal did not hand over to update");
   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load_item |=> state_ff == ST_DECODE)
      else $error("item load without decode");
   a_sum_unit_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SUM) |-> ({1'b0, u_ff} < n_out))
      else $error("sum sweep past last unit");
`endif

endmodule
`default_nettype wire

FILE: rtl/clwu_dp.sv
// clwu_dp: weight memory, sum accumulator, winner pick, reciprocal divider,
// update multiplier and result register. Depends on clwu_pkg.
`default_nettype none
module clwu_dp
   import clwu_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire req_type            req_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output rsp_type                 rsp_data,
   input  wire logic [COUNT_W-1:0] n_in,
   input  wire logic [4:0]         n_out,
   input  wire logic [15:0]        learn_rate,
   input  wire logic               learn_enable,
   input  wire cmd_type            cmd,
   output status_type              status
);

   typedef struct packed {
      logic              valid;
      logic              first;
      logic              last;
      logic              bit_on;
      logic [UNIT_W-1:0] unit;
   } tag_type;

   logic [WEIGHT_W-1:0] mem [MAX_INPUTS*MAX_OUTPUTS];

   req_type                item_ff;
   logic [WEIGHT_W-1:0]    q_ff;
   tag_type                tag_ff;
   logic [SUM_W-1:0]       acc_ff, best_ff, acc_sum;
   logic [UNIT_W-1:0]      win_ff;
   logic [COUNT_W-1:0]     act_ff;
   logic [7:0]             rem_ff, rem_cur, rem_sh;
   logic                   div_ge;
   logic [WEIGHT_W-1:0]    t_ff, t_sel;
   logic signed [34:0]     prod_ff;
   logic signed [17:0]     diff;
   logic signed [19:0]     nw;
   logic [WEIGHT_W-1:0]    nw_clamp, wval_clamp;
   logic [9:0]             addr;
   logic                   line_bit;
   logic                   item_err;
   logic                   rsp_valid_ff;
   rsp_type                rsp_ff;

   always_comb begin
      case (cmd.addr_sel)
         ADDR_ITEM:   addr = {item_ff.unit_index, item_ff.input_index};
         ADDR_SWEEP:  addr = {cmd.unit, cmd.line};
         ADDR_WINNER: addr = {win_ff, cmd.line};
         default:     addr = {item_ff.unit_index, item_ff.input_index};
      endcase
   end

   assign line_bit   = item_ff.pattern_bits[cmd.line];
   assign wval_clamp = (item_ff.weight_value > WEIGHT_ONE) ? WEIGHT_ONE : item_ff.weight_value;

   always_ff @(posedge clock) begin
      if (cmd.mem_wr_item) begin
         mem[addr] <= wval_clamp;
      end else if (cmd.mem_wr_upd) begin
         mem[addr] <= nw_clamp;
      end
      if (cmd.mem_rd) begin
         q_ff <= mem[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         item_ff <= req_data;
      end
   end

   assign acc_sum = (tag_ff.first ? '0 : acc_ff) + (tag_ff.bit_on ? SUM_W'(q_ff) : '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= '0;
      end else begin
         tag_ff.valid  <= cmd.sum_valid;
         tag_ff.first  <= cmd.sum_first;
         tag_ff.last   <= cmd.sum_last;
         tag_ff.bit_on <= line_bit;
         tag_ff.unit   <= cmd.unit;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         act_ff <= '0;
         win_ff <= '0;
      end else if (tag_ff.valid) begin
         acc_ff <= acc_sum;
         if (tag_ff.unit == '0) begin
            act_ff <= act_ff + COUNT_W'(tag_ff.bit_on);
         end
         if (tag_ff.last && (tag_ff.unit == '0 || acc_sum > best_ff)) begin
            best_ff <= acc_sum;
            win_ff  <= tag_ff.unit;
         end
      end
   end

   // restoring divide of 2^16 by the active count, one quotient bit a step
   assign rem_cur = cmd.div_first ? '0 : rem_ff;
   assign rem_sh  = {rem_cur[6:0], cmd.div_first};
   assign div_ge  = (rem_sh >= {1'b0, act_ff});

   always_ff @(posedge clock) begin
      if (cmd.div_step) begin
         rem_ff <= div_ge ? (rem_sh - {1'b0, act_ff}) : rem_sh;
         t_ff   <= {t_ff[WEIGHT_W-2:0], div_ge};
      end
   end

   assign t_sel = line_bit ? t_ff : '0;
   assign diff  = $signed({1'b0, t_sel}) - $signed({1'b0, q_ff});

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         prod_ff <= 35'($signed({1'b0, learn_rate})) * 35'(diff);
      end
   end

   assign nw = $signed({3'b000, q_ff}) + {prod_ff[34], prod_ff[34:16]};

   always_comb begin
      if (nw[19]) begin
         nw_clamp = '0;
      end else if (nw > $signed({3'b000, WEIGHT_ONE})) begin
         nw_clamp = WEIGHT_ONE;
      end else begin
         nw_clamp = nw[WEIGHT_W-1:0];
      end
   end

   always_comb begin
      case (item_ff.kind)
         KIND_WRITE, KIND_READ:
            item_err = ({1'b0, item_ff.unit_index} >= n_out)
                       || ({1'b0, item_ff.input_index} >= n_in);
         KIND_PATTERN: item_err = 1'b0;
         default:      item_err = 1'b1;
      endcase
   end

   assign status.kind     = item_ff.kind;
   assign status.item_err = item_err;
   assign status.learn_go = learn_enable && (act_ff != '0);
   assign status.rsp_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_ff.winner       <= (item_ff.kind == KIND_PATTERN) ? win_ff : '0;
         rsp_ff.active_count <= (item_ff.kind == KIND_PATTERN) ? act_ff : '0;
         rsp_ff.read_value   <= (item_ff.kind == KIND_READ && !item_err) ? q_ff : '0;
         rsp_ff.error        <= item_err;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result overwritten while held");
   a_write_after_mul: assert property (@(posedge clock) disable iff (reset)
      cmd.mem_wr_upd |-> $past(cmd.mul_en))
      else $error("update written without product");
   a_one_write: assert property (@(posedge clock) disable iff (reset)
      !(cmd.mem_wr_item && cmd.mem_wr_upd))
      else $error("two weight writes in one cycle");
`endif

endmodule
`default_nettype wire

FILE: rtl/competitive_learning_winner_update.sv
// competitive_learning_winner_update: top level, CSR registers, controller and datapath.
// Depends on clwu_pkg, clwu_ctrl, clwu_dp.
//
//   channel | direction | handshake          | beat
//   req     | in        | req_valid/stall    | req_type
//   rsp     | out       | rsp_valid/stall    | rsp_type
//   csr     | in/out    | psel/penable/ready | 32-bit register
//
// Write or read item: decode, then result. Pattern: sum sweep over O*I weights
// (one weight memory read a cycle), plus 17 divider steps and a read, multiply
// and write pass per input when learning, for I inputs and O units in use.
// Reset clears control state; weights hold unknown values until written.
// A held result does not block the next item from being accepted.
`default_nettype none
module competitive_learning_winner_update
   import clwu_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output rsp_type          rsp_data,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [3:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   logic [6:0]  num_inputs_ff;
   logic [4:0]  num_outputs_ff;
   logic [15:0] learn_rate_ff;
   logic        learn_enable_ff;
   logic [COUNT_W-1:0] n_in;
   logic [4:0]  n_out;
   cmd_type     cmd;
   status_type  status;

   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_inputs_ff   <= 7'd64;
         num_outputs_ff  <= 5'd16;
         learn_rate_ff   <= 16'd13107;
         learn_enable_ff <= 1'b1;
      end else if (psel && penable && pwrite) begin
         case (paddr[3:2])
            CSR_NUM_INPUTS:   num_inputs_ff   <= pwdata[6:0];
            CSR_NUM_OUTPUTS:  num_outputs_ff  <= pwdata[4:0];
            CSR_LEARN_RATE:   learn_rate_ff   <= pwdata[15:0];
            CSR_LEARN_ENABLE: learn_enable_ff <= pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         CSR_NUM_INPUTS:   prdata = {25'd0, num_inputs_ff};
         CSR_NUM_OUTPUTS:  prdata = {27'd0, num_outputs_ff};
         CSR_LEARN_RATE:   prdata = {16'd0, learn_rate_ff};
         CSR_LEARN_ENABLE: prdata = {31'd0, learn_enable_ff};
         default:          prdata = '0;
      endcase
   end

   always_comb begin
      if (num_inputs_ff == '0) begin
         n_in = 7'd1;
      end else if (num_inputs_ff > 7'(MAX_INPUTS)) begin
         n_in = 7'(MAX_INPUTS);
      end else begin
         n_in = num_inputs_ff;
      end
      if (num_outputs_ff == '0) begin
         n_out = 5'd1;
      end else if (num_outputs_ff > 5'(MAX_OUTPUTS)) begin
         n_out = 5'(MAX_OUTPUTS);
      end else begin
         n_out = num_outputs_ff;
      end
   end

   clwu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .n_in      (n_in),
      .n_out     (n_out),
      .status    (status),
      .cmd       (cmd)
   );

   clwu_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .n_in         (n_in),
      .n_out        (n_out),
      .learn_rate   (learn_rate_ff),
      .learn_enable (learn_enable_ff),
      .cmd          (cmd),
      .status       (status)
   );

endmodule
`default_nettype wire
